/* rtl/core/acpm_pkg.sv */
// Package for the AC current peak monitor: field widths, fixed-point constants,
// the queue command type and the configuration register bundle.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package acpm_pkg;

  // Field and register widths.
  localparam int SAMPLE_W   = 12;
  localparam int GAIN_W     = 14;
  localparam int MV_W       = 12;
  localparam int SPAN_W     = 12;
  localparam int LEN_W      = 8;
  localparam int CUR_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Peak conversion: amps(Q16) = round(m * gain * 2 / PEAK_DIV), where
  // m = max * FULL_SCALE_MV - offset * ADC_MAX.
  localparam int FULL_SCALE_MV = 3300;
  localparam int ADC_MAX       = 4095;
  localparam int SCALED_W      = 25;
  localparam int MMAG_W        = 24;
  localparam int PEAK_DIV      = 102375;
  localparam int PEAK_HALF     = PEAK_DIV / 2;
  localparam int PEAK_SHIFT    = 40;
  localparam int MAG_W         = 40;
  localparam int SPLIT_W       = MAG_W / 2;
  localparam int Q_W           = 24;

  // Shared multiplier.
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int LO_W   = SPLIT_W + Q_W;
  localparam int ACC_W  = LO_W + SPLIT_W;

  // Truncated reciprocal of the peak divisor; the quotient estimate is at
  // most one low and is fixed by a remainder check.
  localparam logic [MUL_W-1:0] PEAK_RECIP =
      MUL_W'((64'd1 << PEAK_SHIFT) / 64'(PEAK_DIV));

  // Low-pass filter: y = round((6x + 3y1 + y2) / 10), exact reciprocal.
  localparam int FILT_W     = 24;
  localparam int NUM_W      = 28;
  localparam int NMAG_W     = 27;
  localparam int FILT_DIV   = 10;
  localparam int FILT_HALF  = FILT_DIV / 2;
  localparam int FILT_SHIFT = 31;
  localparam logic [MUL_W-1:0] FILT_RECIP =
      MUL_W'(((64'd1 << FILT_SHIFT) + 64'(FILT_DIV) - 64'd1) / 64'(FILT_DIV));

  // Reporting and averaging.
  localparam logic [CUR_W-1:0] AMPS_20 = CUR_W'(1310720);
  localparam int REPORTS_PER_AVERAGE   = 600;
  localparam int SUM_W                 = 30;
  localparam logic [SUM_W:0] SUM_MAX   = {1'b0, {SUM_W{1'b1}}};
  localparam int RPT_CNT_W             = $clog2(REPORTS_PER_AVERAGE + 1);
  localparam int DVD_W                 = SUM_W + 1;

  // Average quotient by a reciprocal rounded up; at this shift it is exact for
  // every dividend below 2^DVD_W.
  localparam int AVG_SHIFT = DVD_W + $clog2(REPORTS_PER_AVERAGE);
  localparam logic [MUL_W-1:0] AVG_RECIP =
      MUL_W'(((64'd1 << AVG_SHIFT) + 64'(REPORTS_PER_AVERAGE) - 64'd1) /
             64'(REPORTS_PER_AVERAGE));

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN    = 3'd0,
    REG_OFFSET  = 3'd1,
    REG_NOISE   = 3'd2,
    REG_SAMPLES = 3'd3,
    REG_WINDOWS = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_q12;
    logic [MV_W-1:0]   zero_offset_mv;
    logic [SPAN_W-1:0] noise_span_counts;
    logic [LEN_W-1:0]  samples_per_window;
    logic [LEN_W-1:0]  windows_per_report;
  } cfg_t;

  // One command from the front end: a finished window, a report, or both.
  typedef struct packed {
    logic                win_end;
    logic                report;
    logic [SAMPLE_W-1:0] wmax;
    logic [SAMPLE_W-1:0] wmin;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/ac_current_peak_monitor.sv */
// Top level of the AC current peak monitor: configuration registers, front end,
// command queue and back end. Depends on acpm_pkg, acpm_front, acpm_queue and
// acpm_back.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall  sample
//   out       source     out_valid / out_stall instant_current, average_current,
//                                              average_valid
//   cfg       sink       cfg_we               cfg_index, cfg_data
//
// The front end takes one sample per cycle while the two-entry queue has room;
// only window ends and reports enter the queue.
// The back end steps each command through its shared multiplier: a window end
// runs the peak conversion and the filter, or only the filter when the window
// is below the noise span; a report uses it only when an average is due.
// Reset is synchronous; it restores the register defaults and the control state.
// A held result in the output register does not stop sample transfers until the
// queue fills.
`default_nettype none

module ac_current_peak_monitor (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [acpm_pkg::SAMPLE_W-1:0]       sample,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [acpm_pkg::CUR_W-1:0]               instant_current,
  output logic [acpm_pkg::CUR_W-1:0]               average_current,
  output logic                                     average_valid,
  input  wire logic                                cfg_we,
  input  wire logic [acpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [acpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  acpm_pkg::cfg_t cfg;
  acpm_pkg::cmd_t push_cmd;
  acpm_pkg::cmd_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_q12           <= acpm_pkg::GAIN_W'(4915);
      cfg.zero_offset_mv     <= acpm_pkg::MV_W'(2320);
      cfg.noise_span_counts  <= acpm_pkg::SPAN_W'(63);
      cfg.samples_per_window <= acpm_pkg::LEN_W'(10);
      cfg.windows_per_report <= acpm_pkg::LEN_W'(10);
    end else if (cfg_we) begin
      unique case (acpm_pkg::reg_idx_t'(cfg_index))
        acpm_pkg::REG_GAIN:    cfg.gain_q12           <= cfg_data;
        acpm_pkg::REG_OFFSET:  cfg.zero_offset_mv     <= cfg_data[acpm_pkg::MV_W-1:0];
        acpm_pkg::REG_NOISE:   cfg.noise_span_counts  <= cfg_data[acpm_pkg::SPAN_W-1:0];
        acpm_pkg::REG_SAMPLES: cfg.samples_per_window <= cfg_data[acpm_pkg::LEN_W-1:0];
        acpm_pkg::REG_WINDOWS: cfg.windows_per_report <= cfg_data[acpm_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  acpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  acpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  acpm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (head_valid),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .instant_current (instant_current),
    .average_current (average_current),
    .average_valid   (average_valid)
  );

endmodule

`default_nettype wire

/* rtl/core/acpm_front.sv */
// Front end of the AC current peak monitor: takes samples, tracks the window
// extremes and the window and report counts, and issues commands to the queue.
// Depends on acpm_pkg.
`default_nettype none

module acpm_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire acpm_pkg::cfg_t                    cfg,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [acpm_pkg::SAMPLE_W-1:0]     sample,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output acpm_pkg::cmd_t                         q_cmd
);

  logic [acpm_pkg::SAMPLE_W-1:0] window_max;
  logic [acpm_pkg::SAMPLE_W-1:0] window_min;
  logic [acpm_pkg::LEN_W-1:0]    sample_count;
  logic [acpm_pkg::LEN_W-1:0]    window_count;

  logic                          accept;
  logic [acpm_pkg::SAMPLE_W-1:0] max_next;
  logic [acpm_pkg::SAMPLE_W-1:0] min_next;
  logic [acpm_pkg::LEN_W-1:0]    sample_count_next;
  logic [acpm_pkg::LEN_W-1:0]    window_count_next;
  logic                          win_end;
  logic                          report;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    max_next          = (sample > window_max) ? sample : window_max;
    min_next          = (sample < window_min) ? sample : window_min;
    sample_count_next = sample_count + acpm_pkg::LEN_W'(1);
    win_end           = sample_count_next >= cfg.samples_per_window;
    window_count_next = win_end ? window_count + acpm_pkg::LEN_W'(1) : window_count;
    // The report check runs on every sample, not only at window ends.
    report            = window_count_next >= cfg.windows_per_report;
  end

  assign q_push        = accept && (win_end || report);
  assign q_cmd.win_end = win_end;
  assign q_cmd.report  = report;
  assign q_cmd.wmax    = max_next;
  assign q_cmd.wmin    = min_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_max   <= '0;
      window_min   <= acpm_pkg::SAMPLE_W'(acpm_pkg::ADC_MAX);
      sample_count <= '0;
      window_count <= '0;
    end else if (accept) begin
      if (win_end) begin
        window_max   <= '0;
        window_min   <= acpm_pkg::SAMPLE_W'(acpm_pkg::ADC_MAX);
        sample_count <= '0;
      end else begin
        window_max   <= max_next;
        window_min   <= min_next;
        sample_count <= sample_count_next;
      end
      window_count <= report ? '0 : window_count_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/acpm_queue.sv */
// Two-entry command queue between the front and back ends of the monitor.
// Depends on acpm_pkg for the command type.
`default_nettype none

module acpm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire acpm_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output acpm_pkg::cmd_t      head
);

  acpm_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count != 2'd2)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("command queue read while empty");

endmodule

`default_nettype wire

/* rtl/core/acpm_back.sv */
// Back end of the AC current peak monitor: peak conversion, low-pass filter,
// period minimum, report sum and average, and the result register.
// Depends on acpm_pkg; one shared multiplier is sequenced by the state machine.
`default_nettype none

module acpm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire acpm_pkg::cfg_t                cfg,
  input  wire logic                          q_valid,
  input  wire acpm_pkg::cmd_t                q_head,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [acpm_pkg::CUR_W-1:0]         instant_current,
  output logic [acpm_pkg::CUR_W-1:0]         average_current,
  output logic                               average_valid
);

  typedef enum logic [3:0] {
    B_IDLE, B_PEAK, B_MAG, B_LO, B_HI, B_QUOT, B_QD, B_CORR,
    B_NUM, B_FILT, B_Y, B_RPT, B_AVG, B_EMIT
  } state_t;

  state_t state;

  logic                                 rpt_pending;
  logic [acpm_pkg::MMAG_W-1:0]          m_mag;
  logic                                 m_neg;
  logic [acpm_pkg::PROD_W-1:0]          prod;
  logic [acpm_pkg::MAG_W-1:0]           mag;
  logic [acpm_pkg::LO_W-1:0]            lo_prod;
  logic [acpm_pkg::Q_W-1:0]             q0;
  logic signed [acpm_pkg::FILT_W-1:0]   x_val;
  logic signed [acpm_pkg::FILT_W-1:0]   filter_prev1;
  logic signed [acpm_pkg::FILT_W-1:0]   filter_prev2;
  logic [acpm_pkg::NMAG_W-1:0]          n_mag;
  logic                                 n_neg;
  logic [acpm_pkg::CUR_W-1:0]           period_min;
  logic [acpm_pkg::SUM_W-1:0]           report_sum;
  logic [acpm_pkg::RPT_CNT_W-1:0]       report_count;
  logic [acpm_pkg::DVD_W-1:0]           dvd;
  logic                                 avg_flag;
  logic [acpm_pkg::CUR_W-1:0]           inst_hold;

  logic [acpm_pkg::MUL_W-1:0]           mul_a;
  logic [acpm_pkg::MUL_W-1:0]           mul_b;
  logic [acpm_pkg::PROD_W-1:0]          mul_p;
  logic [acpm_pkg::SCALED_W-1:0]        mv_scaled;
  logic [acpm_pkg::SCALED_W-1:0]        off_scaled;
  logic                                 noisy;
  logic [acpm_pkg::ACC_W-1:0]           acc;
  logic [acpm_pkg::MAG_W-1:0]           rem_peak;
  logic [acpm_pkg::Q_W-1:0]             q_fin;
  logic signed [acpm_pkg::NUM_W-1:0]    xe;
  logic signed [acpm_pkg::NUM_W-1:0]    p1e;
  logic signed [acpm_pkg::NUM_W-1:0]    p2e;
  logic signed [acpm_pkg::NUM_W-1:0]    n_sum;
  logic [acpm_pkg::NUM_W-1:0]           n_abs;
  logic [acpm_pkg::FILT_W-1:0]          y_mag;
  logic signed [acpm_pkg::FILT_W-1:0]   y_val;
  logic [acpm_pkg::SUM_W:0]             sum_wide;
  logic [acpm_pkg::SUM_W-1:0]           sum_sat;
  logic [acpm_pkg::RPT_CNT_W-1:0]       count_inc;
  logic                                 out_free;

  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_free = !out_valid || !out_stall;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state)
      B_PEAK: begin
        mul_a = acpm_pkg::MUL_W'(m_mag);
        mul_b = acpm_pkg::MUL_W'(cfg.gain_q12);
      end
      B_LO: begin
        mul_a = acpm_pkg::MUL_W'(mag[acpm_pkg::SPLIT_W-1:0]);
        mul_b = acpm_pkg::PEAK_RECIP;
      end
      B_HI: begin
        mul_a = acpm_pkg::MUL_W'(mag[acpm_pkg::MAG_W-1:acpm_pkg::SPLIT_W]);
        mul_b = acpm_pkg::PEAK_RECIP;
      end
      B_QD: begin
        mul_a = acpm_pkg::MUL_W'(q0);
        mul_b = acpm_pkg::MUL_W'(acpm_pkg::PEAK_DIV);
      end
      B_FILT: begin
        mul_a = acpm_pkg::MUL_W'(n_mag);
        mul_b = acpm_pkg::FILT_RECIP;
      end
      B_AVG: begin
        mul_a = acpm_pkg::MUL_W'(dvd);
        mul_b = acpm_pkg::AVG_RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mv_scaled  = acpm_pkg::SCALED_W'(q_head.wmax) *
                 acpm_pkg::SCALED_W'(acpm_pkg::FULL_SCALE_MV);
    off_scaled = acpm_pkg::SCALED_W'(cfg.zero_offset_mv) *
                 acpm_pkg::SCALED_W'(acpm_pkg::ADC_MAX);
    // A window whose extremes are crossed never held a sample; it reads as zero.
    noisy      = (q_head.wmax < q_head.wmin) ||
                 ((q_head.wmax - q_head.wmin) < cfg.noise_span_counts);

    acc      = {prod[acpm_pkg::LO_W-1:0], acpm_pkg::SPLIT_W'(0)} +
               acpm_pkg::ACC_W'(lo_prod);
    rem_peak = mag - prod[acpm_pkg::MAG_W-1:0];
    q_fin    = (rem_peak >= acpm_pkg::MAG_W'(acpm_pkg::PEAK_DIV)) ?
               q0 + acpm_pkg::Q_W'(1) : q0;

    xe    = acpm_pkg::NUM_W'(x_val);
    p1e   = acpm_pkg::NUM_W'(filter_prev1);
    p2e   = acpm_pkg::NUM_W'(filter_prev2);
    n_sum = (xe <<< 2) + (xe <<< 1) + (p1e <<< 1) + p1e + p2e;
    n_abs = n_sum[acpm_pkg::NUM_W-1] ? acpm_pkg::NUM_W'(0) - n_sum : n_sum;

    y_mag = prod[acpm_pkg::FILT_SHIFT +: acpm_pkg::FILT_W];
    y_val = n_neg ? acpm_pkg::FILT_W'(0) - y_mag : y_mag;

    sum_wide  = {1'b0, report_sum} + (acpm_pkg::SUM_W + 1)'(period_min);
    sum_sat   = (sum_wide > acpm_pkg::SUM_MAX) ?
                acpm_pkg::SUM_MAX[acpm_pkg::SUM_W-1:0] : sum_wide[acpm_pkg::SUM_W-1:0];
    count_inc = report_count + acpm_pkg::RPT_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      out_valid    <= 1'b0;
      filter_prev1 <= '0;
      filter_prev2 <= '0;
      period_min   <= acpm_pkg::AMPS_20;
      report_sum   <= '0;
      report_count <= '0;
      rpt_pending  <= 1'b0;
      avg_flag     <= 1'b0;
    end else begin
      // A new result loaded in B_EMIT keeps the valid flag set instead.
      if (out_valid && !out_stall && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            rpt_pending <= q_head.report;
            if (mv_scaled >= off_scaled) begin
              m_mag <= acpm_pkg::MMAG_W'(mv_scaled - off_scaled);
              m_neg <= 1'b0;
            end else begin
              m_mag <= acpm_pkg::MMAG_W'(off_scaled - mv_scaled);
              m_neg <= 1'b1;
            end
            if (!q_head.win_end) begin
              state <= B_RPT;
            end else if (noisy) begin
              x_val <= '0;
              state <= B_NUM;
            end else begin
              state <= B_PEAK;
            end
          end
        end
        B_PEAK: begin
          prod  <= mul_p;
          state <= B_MAG;
        end
        B_MAG: begin
          mag   <= {prod[acpm_pkg::MAG_W-2:0], 1'b0} +
                   acpm_pkg::MAG_W'(acpm_pkg::PEAK_HALF);
          state <= B_LO;
        end
        B_LO: begin
          prod  <= mul_p;
          state <= B_HI;
        end
        B_HI: begin
          lo_prod <= prod[acpm_pkg::LO_W-1:0];
          prod    <= mul_p;
          state   <= B_QUOT;
        end
        B_QUOT: begin
          q0    <= acc[acpm_pkg::ACC_W-1 -: acpm_pkg::Q_W];
          state <= B_QD;
        end
        B_QD: begin
          prod  <= mul_p;
          state <= B_CORR;
        end
        B_CORR: begin
          x_val <= m_neg ? acpm_pkg::Q_W'(0) - q_fin : q_fin;
          state <= B_NUM;
        end
        B_NUM: begin
          n_mag <= acpm_pkg::NMAG_W'(n_abs) + acpm_pkg::NMAG_W'(acpm_pkg::FILT_HALF);
          n_neg <= n_sum[acpm_pkg::NUM_W-1];
          state <= B_FILT;
        end
        B_FILT: begin
          prod  <= mul_p;
          state <= B_Y;
        end
        B_Y: begin
          filter_prev2 <= filter_prev1;
          filter_prev1 <= y_val;
          if (y_val < 0) begin
            period_min <= '0;
          end else if (y_val[acpm_pkg::FILT_W-2:0] <
                       (acpm_pkg::FILT_W - 1)'(period_min)) begin
            period_min <= y_val[acpm_pkg::CUR_W-1:0];
          end
          state <= rpt_pending ? B_RPT : B_IDLE;
        end
        B_RPT: begin
          inst_hold  <= period_min;
          period_min <= acpm_pkg::AMPS_20;
          if (count_inc >= acpm_pkg::RPT_CNT_W'(acpm_pkg::REPORTS_PER_AVERAGE)) begin
            dvd          <= (acpm_pkg::DVD_W)'(sum_sat) +
                            (acpm_pkg::DVD_W)'(acpm_pkg::REPORTS_PER_AVERAGE / 2);
            avg_flag     <= 1'b1;
            report_sum   <= '0;
            report_count <= '0;
            state        <= B_AVG;
          end else begin
            avg_flag     <= 1'b0;
            report_sum   <= sum_sat;
            report_count <= count_inc;
            state        <= B_EMIT;
          end
        end
        B_AVG: begin
          // The rounded sum times the reciprocal; the quotient sits above
          // AVG_SHIFT and stays there until the result is loaded.
          prod  <= mul_p;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            instant_current <= inst_hold;
            average_current <= avg_flag ?
                               prod[acpm_pkg::AVG_SHIFT +: acpm_pkg::CUR_W] : '0;
            average_valid   <= avg_flag;
            state           <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_min_restarts: assert property (@(posedge clk) disable iff (rst)
    state == B_RPT |=> period_min == acpm_pkg::AMPS_20)
    else $error("period minimum not restarted after a report");

  a_avg_exit: assert property (@(posedge clk) disable iff (rst)
    state == B_AVG |=> state == B_EMIT)
    else $error("average multiply not followed by the result load");

  a_avg_clears: assert property (@(posedge clk) disable iff (rst)
    state == B_EMIT && avg_flag |-> report_count == '0 && report_sum == '0)
    else $error("report sum not cleared with an average");

  a_min_range: assert property (@(posedge clk) disable iff (rst)
    state == B_Y |=> period_min <= acpm_pkg::AMPS_20)
    else $error("period minimum above its start value");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ac_current_peak_monitor: a queue-fed sample driver,
// a randomly stalling result monitor and a cycle-free predictor of the reports.
// Depends on acpm_pkg for widths and register indexes, and on the block itself.

module testbench;

  localparam longint MV_FULL         = 3300;
  localparam longint ADC_FULL        = 4095;
  localparam longint PEAK_DEN        = 102375;
  localparam longint FILT_DEN        = 10;
  localparam int     AMPS_20A        = 20 * 65536;
  localparam int     REPORTS_PER_AVG = 600;
  localparam longint SUM_CAP         = (64'd1 << 30) - 1;
  localparam int     DRAIN_CYCLES    = 200;
  localparam logic [acpm_pkg::CFG_IDX_W-1:0] UNUSED_IDX_LO =
      acpm_pkg::CFG_IDX_W'(acpm_pkg::REG_WINDOWS + 1);

  typedef struct packed {
    logic [acpm_pkg::CUR_W-1:0] inst;
    logic [acpm_pkg::CUR_W-1:0] avg;
    logic                       avg_ok;
  } report_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_LONG} stall_mode_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [acpm_pkg::SAMPLE_W-1:0]   sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [acpm_pkg::CUR_W-1:0]      instant_current;
  logic [acpm_pkg::CUR_W-1:0]      average_current;
  logic                            average_valid;
  logic                            cfg_we = 1'b0;
  logic [acpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [acpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  ac_current_peak_monitor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .instant_current(instant_current), .average_current(average_current),
    .average_valid(average_valid),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predictor state and its copy of the registers.
  logic [acpm_pkg::GAIN_W-1:0]   cfg_gain;
  logic [acpm_pkg::MV_W-1:0]     cfg_offset;
  logic [acpm_pkg::SPAN_W-1:0]   cfg_noise;
  logic [acpm_pkg::LEN_W-1:0]    cfg_spw;
  logic [acpm_pkg::LEN_W-1:0]    cfg_wpr;
  logic [acpm_pkg::SAMPLE_W-1:0] adc_hi;
  logic [acpm_pkg::SAMPLE_W-1:0] adc_lo;
  logic [7:0]          tick_count;
  logic [7:0]          window_total;
  logic [9:0]          report_total;
  int                  lp_prev1;
  int                  lp_prev2;
  int                  floor_amps;
  longint              amps_sum;

  report_t     due_reports[$];
  logic [acpm_pkg::SAMPLE_W-1:0] sample_backlog[$];
  int          pushed_total = 0;
  int          accepted_total = 0;
  int          error_count = 0;
  report_t     seen_report;

  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        stall_level = 1'b0;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic void reset_model();
    cfg_gain     = 14'd4915;
    cfg_offset   = 12'd2320;
    cfg_noise    = 12'd63;
    cfg_spw      = 8'd10;
    cfg_wpr      = 8'd10;
    adc_hi       = '0;
    adc_lo       = '1;
    tick_count   = '0;
    window_total = '0;
    report_total = '0;
    lp_prev1     = 0;
    lp_prev2     = 0;
    floor_amps   = AMPS_20A;
    amps_sum     = 0;
  endfunction

  // Peak conversion of the finished window, then the low-pass filter and the
  // running minimum of the report period.
  function automatic void close_window();
    longint m;
    longint x;
    longint y;
    x = 0;
    if (adc_hi >= adc_lo && (adc_hi - adc_lo) >= cfg_noise) begin
      m = longint'(adc_hi) * MV_FULL - longint'(cfg_offset) * ADC_FULL;
      x = round_div(m * longint'(cfg_gain) * 2, PEAK_DEN);
    end
    y = round_div(6 * x + 3 * longint'(lp_prev1) + longint'(lp_prev2), FILT_DEN);
    lp_prev2 = lp_prev1;
    lp_prev1 = int'(y);
    if (y < longint'(floor_amps)) floor_amps = int'(y);
    if (floor_amps < 0) floor_amps = 0;
    window_total = window_total + 8'd1;
    adc_hi = '0;
    adc_lo = '1;
    tick_count = '0;
  endfunction

  function automatic void take_sample(input logic [acpm_pkg::SAMPLE_W-1:0] s);
    report_t r;
    if (s > adc_hi) adc_hi = s;
    if (s < adc_lo) adc_lo = s;
    tick_count = tick_count + 8'd1;
    if (tick_count >= cfg_spw) close_window();
    if (window_total < cfg_wpr) return;
    r.inst = acpm_pkg::CUR_W'(floor_amps);
    r.avg = '0;
    r.avg_ok = 1'b0;
    amps_sum = amps_sum + longint'(floor_amps);
    if (amps_sum > SUM_CAP) amps_sum = SUM_CAP;
    report_total = report_total + 10'd1;
    floor_amps = AMPS_20A;
    window_total = '0;
    if (report_total >= REPORTS_PER_AVG && report_total != 0) begin
      r.avg = acpm_pkg::CUR_W'((amps_sum + longint'(report_total) / 2) /
                               longint'(report_total));
      r.avg_ok = 1'b1;
      amps_sum = 0;
      report_total = '0;
    end
    due_reports.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // Sample driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_sample(sample);
        accepted_total++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_backlog.size() > 0) begin
          sample <= sample_backlog.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stall pattern: quiet stretches, coin flips and long holds.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        if (run_left == 0) begin
          stall_level = ~stall_level;
          run_left = $urandom_range(1, 30);
        end
        run_left--;
        out_stall <= stall_level;
      end
    endcase
  end

  // Every result transfer is matched against the oldest predicted report.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_reports.size() == 0) begin
        flag_mismatch($sformatf("unpredicted result instant=%0d", instant_current));
      end else begin
        seen_report = due_reports.pop_front();
        if (instant_current !== seen_report.inst)
          flag_mismatch($sformatf("instant_current %0d, predicted %0d",
                                  instant_current, seen_report.inst));
        if (average_current !== seen_report.avg)
          flag_mismatch($sformatf("average_current %0d, predicted %0d",
                                  average_current, seen_report.avg));
        if (average_valid !== seen_report.avg_ok)
          flag_mismatch($sformatf("average_valid %0b, predicted %0b",
                                  average_valid, seen_report.avg_ok));
      end
    end
  end

  task automatic write_reg(input logic [acpm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [acpm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      acpm_pkg::REG_GAIN:    cfg_gain   = data[acpm_pkg::GAIN_W-1:0];
      acpm_pkg::REG_OFFSET:  cfg_offset = data[acpm_pkg::MV_W-1:0];
      acpm_pkg::REG_NOISE:   cfg_noise  = data[acpm_pkg::SPAN_W-1:0];
      acpm_pkg::REG_SAMPLES: cfg_spw    = data[acpm_pkg::LEN_W-1:0];
      acpm_pkg::REG_WINDOWS: cfg_wpr    = data[acpm_pkg::LEN_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random bits above the register width must be dropped by the block.
  function automatic logic [acpm_pkg::CFG_DATA_W-1:0] with_junk(int value, int width);
    return acpm_pkg::CFG_DATA_W'(value) | acpm_pkg::CFG_DATA_W'($urandom << width);
  endfunction

  task automatic set_regs(int g, int o, int n, int s, int w);
    write_reg(acpm_pkg::REG_GAIN, acpm_pkg::CFG_DATA_W'(g));
    write_reg(acpm_pkg::REG_OFFSET, with_junk(o, acpm_pkg::MV_W));
    write_reg(acpm_pkg::REG_NOISE, with_junk(n, acpm_pkg::SPAN_W));
    write_reg(acpm_pkg::REG_SAMPLES, with_junk(s, acpm_pkg::LEN_W));
    write_reg(acpm_pkg::REG_WINDOWS, with_junk(w, acpm_pkg::LEN_W));
  endtask

  task automatic send(int v);
    sample_backlog.push_back(acpm_pkg::SAMPLE_W'(v));
    pushed_total++;
  endtask

  // Waits until every queued sample is taken and every report has arrived,
  // then lets a window end that produces no result finish inside the block.
  task automatic settle();
    while (accepted_total != pushed_total) @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_sample(int center, int spread);
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? int'(ADC_FULL) : 0;
      1, 2, 3: v = $urandom_range(0, int'(ADC_FULL));
      default: v = center - spread + $urandom_range(0, 2 * spread);
    endcase
    if (v < 0) v = 0;
    if (v > ADC_FULL) v = int'(ADC_FULL);
    return v;
  endfunction

  function automatic int pick_noise();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 63;
      2:       return $urandom_range(0, 300);
      default: return $urandom_range(0, int'(ADC_FULL));
    endcase
  endfunction

  task automatic random_phase(int g, int o, int n, int s, int w, int count);
    int center;
    int spread;
    settle();
    set_regs(g, o, n, s, w);
    center = $urandom_range(0, int'(ADC_FULL));
    case ($urandom_range(0, 2))
      0:       spread = 3;
      1:       spread = 30;
      default: spread = 300;
    endcase
    repeat (count) send(pick_sample(center, spread));
  endtask

  initial begin
    int k;
    int unsigned corner_pairs [14] = '{0, 4095, 4095, 4095, 0, 0, 4095, 0,
                                       2000, 2100, 2000, 2062, 2000, 2063};
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Two-sample windows, one report each: full swing, flat tops, and spans
    // just under and right at the noise threshold.
    set_regs(4915, 2320, 63, 2, 1);
    foreach (corner_pairs[i]) send(corner_pairs[i]);

    // Zero lengths end a window and a report on every sample; the large offset
    // drives the current negative so the clamp at zero is hit.
    settle();
    set_regs(16383, 3300, 0, 0, 0);
    send(0);
    send(4095);
    send(1234);

    // A long window cut short by lowering its length while it is open, plus a
    // write to an unused index that must change nothing.
    settle();
    set_regs($urandom_range(0, 16383), 1000, 10, 200, 1);
    repeat (5) send($urandom_range(0, int'(ADC_FULL)));
    settle();
    write_reg(acpm_pkg::CFG_IDX_W'($urandom_range(UNUSED_IDX_LO,
                                                  (1 << acpm_pkg::CFG_IDX_W) - 1)),
              acpm_pkg::CFG_DATA_W'($urandom));
    write_reg(acpm_pkg::REG_SAMPLES, with_junk(3, acpm_pkg::LEN_W));
    send($urandom_range(0, int'(ADC_FULL)));

    for (k = 0; k < 3; k++)
      random_phase($urandom_range(0, 16383), $urandom_range(0, 3300), pick_noise(),
                   $urandom_range(0, 6), $urandom_range(0, 4), 40);

    // Short windows and reports so the running average completes.
    for (k = 0; k < 4; k++) begin
      random_phase($urandom_range(0, 16383), $urandom_range(0, 3300),
                   ($urandom_range(0, 3) == 0) ? pick_noise() : 0,
                   $urandom_range(0, 1), $urandom_range(0, 1), 150);
      if (k == 1) random_phase($urandom_range(0, 16383), 0, 0, 255, 1, 255);
    end
    random_phase(0, 3300, 4095, 1, 255, 255);

    settle();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
